@@ design/button_click_classifier_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the button click classifier
// Concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef BUTTON_CLICK_CLASSIFIER_TOP_MACROS_SVH
`define BUTTON_CLICK_CLASSIFIER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define BCC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bcc assertion failed");

// antecedent implies consequent in the next cycle
`define BCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bcc assertion failed");

`else

`define BCC_ASSERT_SAME(label, ante, cons)
`define BCC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ design/bcc_pkg.sv @@
// ----------------------------------------------------------------------------
// bcc_pkg
// Types and constants shared by the button click classifier
// ----------------------------------------------------------------------------
package bcc_pkg;

    localparam int LIMIT_W           = 8;
    localparam int COUNT_WIDTH_DEF   = 8;
    localparam int CFG_IDX_W         = 1;

    localparam logic [LIMIT_W-1:0] LONG_PRESS_LIMIT_RST = 8'd120;
    localparam logic [LIMIT_W-1:0] CLICK_GAP_LIMIT_RST  = 8'd35;

    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CLICK_GAP_LIMIT  = 1'b1;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } event_t;

    typedef enum logic [5:0] {
        PH_IDLE        = 6'b000001,
        PH_FIRST       = 6'b000010,
        PH_HELD        = 6'b000100,
        PH_LONG_WAIT   = 6'b001000,
        PH_GAP         = 6'b010000,
        PH_DOUBLE_WAIT = 6'b100000
    } phase_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] long_press_limit;
        logic [LIMIT_W-1:0] click_gap_limit;
    } limits_t;

endpackage

@@ design/bcc_key_if.sv @@
// ----------------------------------------------------------------------------
// bcc_key_if
// Channel carrying one sampled key level per beat
// ----------------------------------------------------------------------------
interface bcc_key_if;

    logic valid;
    logic ready;
    logic key_active;

    modport source (output valid, output key_active, input ready);
    modport sink   (input valid, input key_active, output ready);

endinterface

@@ design/bcc_event_if.sv @@
// ----------------------------------------------------------------------------
// bcc_event_if
// Channel carrying one event code per beat
// ----------------------------------------------------------------------------
interface bcc_event_if;

    logic       valid;
    logic       ready;
    logic [1:0] event_res;

    modport source (output valid, output event_res, input ready);
    modport sink   (input valid, input event_res, output ready);

endinterface

@@ design/button_click_classifier_top.sv @@
// ----------------------------------------------------------------------------
// button_click_classifier_top
// Classifies a sampled key into single click, double click and long press
// ----------------------------------------------------------------------------
// Each sample beat carries the key level of one sampling tick and yields one
// result beat with an event code (0 none, 1 single, 2 double, 3 long press).
// One sample is taken every clock cycle unless the result side stalls with the
// result register full. A sample is captured in the input register, which feeds
// the combinational next-state logic of the phase machine; that logic loads the
// result register, which drives the result beat. The user must write limits on
// the cfg port only while no sample is in flight; the block does not enforce it.
module button_click_classifier_top
    import bcc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LIMIT_W-1:0]   cfg_data,
    bcc_key_if.sink              sample,
    bcc_event_if.source          result
);

    limits_t limits_reg;
    logic    in_valid_reg;
    logic    key_reg;
    logic    out_valid_reg;
    event_t  event_reg;
    event_t  ev;
    logic    advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.long_press_limit <= LONG_PRESS_LIMIT_RST;
            limits_reg.click_gap_limit  <= CLICK_GAP_LIMIT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_LONG_PRESS_LIMIT: limits_reg.long_press_limit <= cfg_data;
                REG_CLICK_GAP_LIMIT:  limits_reg.click_gap_limit  <= cfg_data;
                default:              limits_reg <= limits_reg;
            endcase
        end
    end

    // sample moves on when the result register is free or being drained
    assign advance      = in_valid_reg && (!out_valid_reg || result.ready);
    assign sample.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            in_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.ready && sample.valid)
        begin
            key_reg <= sample.key_active;
        end
    end

    bcc_fsm #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_fsm (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .key    (key_reg),
        .limits (limits_reg),
        .ev     (ev)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            event_reg <= ev;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.event_res = event_reg;

endmodule

@@ design/bcc_fsm.sv @@
// ----------------------------------------------------------------------------
// bcc_fsm
// Press / release sequence tracker with held and gap tick counter
// ----------------------------------------------------------------------------
`include "button_click_classifier_top_macros.svh"

module bcc_fsm
    import bcc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  logic    key,
    input  limits_t limits,
    output event_t  ev
);

    localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

    phase_t                 phase_reg;
    phase_t                 phase_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic [COUNT_WIDTH-1:0] count_inc;
    logic                   held_over;
    logic                   gap_over;

    // saturating increment
    assign count_inc = (count_reg == '1) ? count_reg : count_reg + 1'b1;
    assign held_over = CMP_W'(count_inc) > CMP_W'(limits.long_press_limit);
    assign gap_over  = CMP_W'(count_inc) > CMP_W'(limits.click_gap_limit);

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        ev         = EV_NONE;
        case (phase_reg)
            PH_FIRST:
            begin
                phase_next = key ? PH_HELD : PH_IDLE;
                count_next = '0;
            end
            PH_HELD:
            begin
                if (key)
                begin
                    count_next = count_inc;
                    if (held_over)
                    begin
                        ev         = EV_LONG;
                        phase_next = PH_LONG_WAIT;
                    end
                end
                else
                begin
                    phase_next = PH_GAP;
                    count_next = '0;
                end
            end
            PH_LONG_WAIT, PH_DOUBLE_WAIT:
            begin
                if (!key)
                begin
                    phase_next = PH_IDLE;
                    count_next = '0;
                end
            end
            PH_GAP:
            begin
                if (key)
                begin
                    ev         = EV_DOUBLE;
                    phase_next = PH_DOUBLE_WAIT;
                    count_next = '0;
                end
                else
                begin
                    count_next = count_inc;
                    if (gap_over)
                    begin
                        ev         = EV_SINGLE;
                        phase_next = PH_IDLE;
                        count_next = '0;
                    end
                end
            end
            default:
            begin
                // idle, and any code that cannot be reached
                phase_next = key ? PH_FIRST : PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    `BCC_ASSERT_NEXT(a_long_enters_wait, step && ev == EV_LONG, phase_reg == PH_LONG_WAIT)
    `BCC_ASSERT_NEXT(a_gap_press_double, step && phase_reg == PH_GAP && key,
                     phase_reg == PH_DOUBLE_WAIT && count_reg == '0)
    `BCC_ASSERT_NEXT(a_hold_when_idle, !step, $stable(phase_reg) && $stable(count_reg))

endmodule

@@ tb/sv/bcc_event_checker.sv @@
// ----------------------------------------------------------------------------
// bcc_event_checker
// Predicts the event code of every key sample beat and compares each result
// beat against it in order; counts mismatches and reports results still owed
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module bcc_event_checker
    import bcc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LIMIT_W-1:0]   cfg_data,
    bcc_key_if                   sample,
    bcc_event_if                 result,
    output int                   fail_count,
    output int                   pending
);

    localparam logic [COUNT_WIDTH_DEF-1:0] COUNT_MAX = '1;

    logic [LIMIT_W-1:0]         long_limit;
    logic [LIMIT_W-1:0]         gap_limit;
    phase_t                     phase;
    logic [COUNT_WIDTH_DEF-1:0] tick_cnt;
    event_t                     event_q[$];
    int                         errors = 0;
    int                         queued = 0;

    assign fail_count = errors;
    assign pending    = queued;

    function automatic logic [COUNT_WIDTH_DEF-1:0] count_up(
        input logic [COUNT_WIDTH_DEF-1:0] c);
        return (c == COUNT_MAX) ? c : c + 1'b1;
    endfunction

    // advances the phase machine by one sampling tick, returns the event
    function automatic event_t classify_tick(input logic pressed);
        event_t ev;
        ev = EV_NONE;
        case (phase)
            PH_FIRST:
            begin
                phase    = pressed ? PH_HELD : PH_IDLE;
                tick_cnt = '0;
            end
            PH_HELD:
            begin
                if (pressed)
                begin
                    tick_cnt = count_up(tick_cnt);
                    if (tick_cnt > long_limit)
                    begin
                        ev    = EV_LONG;
                        phase = PH_LONG_WAIT;
                    end
                end
                else
                begin
                    phase    = PH_GAP;
                    tick_cnt = '0;
                end
            end
            PH_LONG_WAIT, PH_DOUBLE_WAIT:
            begin
                if (!pressed)
                begin
                    phase    = PH_IDLE;
                    tick_cnt = '0;
                end
            end
            PH_GAP:
            begin
                if (pressed)
                begin
                    ev       = EV_DOUBLE;
                    phase    = PH_DOUBLE_WAIT;
                    tick_cnt = '0;
                end
                else
                begin
                    tick_cnt = count_up(tick_cnt);
                    if (tick_cnt > gap_limit)
                    begin
                        ev       = EV_SINGLE;
                        phase    = PH_IDLE;
                        tick_cnt = '0;
                    end
                end
            end
            default:
            begin
                phase = pressed ? PH_FIRST : PH_IDLE;
            end
        endcase
        return ev;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        event_t want;
        if (!rst_n)
        begin
            long_limit = LONG_PRESS_LIMIT_RST;
            gap_limit  = CLICK_GAP_LIMIT_RST;
            phase      = PH_IDLE;
            tick_cnt   = '0;
            event_q.delete();
            queued     = 0;
        end
        else
        begin
            // result beat first so it is never matched to this edge's sample
            if (result.valid && result.ready)
            begin
                if (event_q.size() == 0)
                begin
                    $display("%0t unexpected result beat: expected none, got %0d",
                             $time, result.event_res);
                    errors++;
                end
                else
                begin
                    want = event_q.pop_front();
                    if (result.event_res !== want)
                    begin
                        $display("%0t event_res mismatch: expected %0d, got %0d",
                                 $time, want, result.event_res);
                        errors++;
                    end
                end
            end
            if (sample.valid && sample.ready)
                event_q.push_back(classify_tick(sample.key_active));
            if (cfg_wr_en)
            begin
                if (cfg_index == REG_LONG_PRESS_LIMIT)
                    long_limit = cfg_data;
                else if (cfg_index == REG_CLICK_GAP_LIMIT)
                    gap_limit = cfg_data;
            end
            queued = event_q.size();
        end
    end

endmodule

@@ tb/sv/tb_button_click_classifier_top.sv @@
// ----------------------------------------------------------------------------
// tb_button_click_classifier_top
// Drives key press and release patterns into the click classifier under a
// series of limit settings, with random gaps and stalls on both channels;
// the checker beside the block predicts and compares every event code
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_button_click_classifier_top;
    import bcc_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 14;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 4;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [LIMIT_W-1:0]   cfg_data;

    bcc_key_if   sample ();
    bcc_event_if result ();

    int fail_count;
    int pending;
    int cycles     = 0;
    int hold_left  = 0;
    bit calm       = 1'b0;
    bit hold_req   = 1'b0;
    int cur_long   = LONG_PRESS_LIMIT_RST;
    int cur_gap    = CLICK_GAP_LIMIT_RST;

    button_click_classifier_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample.sink),
        .result    (result.source)
    );

    bcc_event_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample     (sample),
        .result     (result),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result.ready <= 1'b0;
        end
        else if (calm)
            result.ready <= 1'b1;
        else
            result.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
    end

    task automatic send_tick(input logic key);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            sample.valid <= 1'b0;
            @(negedge clk);
        end
        sample.valid      <= 1'b1;
        sample.key_active <= key;
        @(posedge clk);
        while (!sample.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // stop offering beats until every event has come back
    task automatic drain();
        sample.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic apply_limits(input int long_lim, input int gap_lim);
        drain();
        repeat (DRAIN_WAIT) @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_LONG_PRESS_LIMIT;
        cfg_data  <= long_lim[LIMIT_W-1:0];
        @(negedge clk);
        cfg_index <= REG_CLICK_GAP_LIMIT;
        cfg_data  <= gap_lim[LIMIT_W-1:0];
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        cur_long = long_lim;
        cur_gap  = gap_lim;
    endtask

    // run length biased toward the tick at which an event fires
    function automatic int pick_len(input int fire_at);
        int sel;
        int len;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            len = $urandom_range(1, 4);
        else if (sel < 7)
            len = fire_at + $urandom_range(0, 3) - 2;
        else
            len = $urandom_range(1, fire_at + 1);
        return (len < 1) ? 1 : len;
    endfunction

    task automatic run_gestures(input int budget);
        int sent;
        int press_len;
        int release_len;
        sent = 0;
        while (sent < budget)
        begin
            if ($urandom_range(0, 99) < 10)
            begin
                repeat ($urandom_range(1, 8))
                begin
                    send_tick(1'($urandom_range(0, 1)));
                    sent++;
                end
            end
            else
            begin
                // long press fires on press tick limit+3, single on release limit+2
                press_len   = pick_len(cur_long + 3);
                release_len = pick_len(cur_gap + 2);
                repeat (press_len) send_tick(1'b1);
                repeat (release_len) send_tick(1'b0);
                sent += press_len + release_len;
            end
            if ($urandom_range(0, 99) < 3)
                drain();
        end
    endtask

    task automatic send_pattern(input logic [31:0] bits, input int n);
        for (int i = n - 1; i >= 0; i--)
            send_tick(bits[i]);
    endtask

    initial
    begin
        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_index         = REG_LONG_PRESS_LIMIT;
        cfg_data          = '0;
        sample.valid      = 1'b0;
        sample.key_active = 1'b0;
        result.ready      = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        run_gestures(60);

        // zero limits: first counted tick fires
        apply_limits(0, 0);
        send_pattern(32'b10, 2);        // first press then release
        send_pattern(32'b1110, 4);      // long press, release
        send_pattern(32'b1100, 4);      // single click
        send_pattern(32'b110110, 6);    // double click, hold, release
        send_pattern(32'b00, 2);        // idle
        send_pattern(32'b11010, 5);     // double click, release
        run_gestures(50);

        // highest limits that can still fire, gestures here run to about 500 ticks
        apply_limits(254, 254);
        run_gestures(120);

        apply_limits(3, 4);
        calm = 1'b1;
        run_gestures(100);
        calm = 1'b0;

        apply_limits($urandom_range(0, 20), $urandom_range(0, 20));
        hold_req = 1'b1;
        run_gestures(80);
        apply_limits($urandom_range(0, 254), $urandom_range(0, 30));
        run_gestures(50);

        drain();
        repeat (DRAIN_WAIT * 2) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
